[rtl/qpr_pkg.sv]
// ----------------------------------------------------------------------------
// qpr_pkg: shared types and constants
// Word widths, register indexes, sequencer states and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package qpr_pkg;

	localparam int unsigned WordW  = 32;   // Q16.16 samples, Q4.28 coefficients
	localparam int unsigned GainW  = 31;   // inverse_gain and output_limit
	localparam int unsigned IndexW = 3;    // configuration register index
	localparam int unsigned ProdW  = 64;   // registered product
	localparam int unsigned AccW   = 67;   // five products summed exactly
	localparam int unsigned FracSh = 28;   // Q20.44 sum down to Q16.16
	localparam int unsigned AwSh   = 16;   // Q32.32 anti-windup product down to Q16.16

	// configuration register indexes
	localparam logic [IndexW-1:0] REG_B0    = 3'd0;
	localparam logic [IndexW-1:0] REG_B1    = 3'd1;
	localparam logic [IndexW-1:0] REG_B2    = 3'd2;
	localparam logic [IndexW-1:0] REG_A1    = 3'd3;
	localparam logic [IndexW-1:0] REG_A2    = 3'd4;
	localparam logic [IndexW-1:0] REG_INVG  = 3'd5;
	localparam logic [IndexW-1:0] REG_LIMIT = 3'd6;

	localparam logic [GainW-1:0] InvGainReset = 31'd65536;
	localparam logic [GainW-1:0] LimitReset   = 31'h7fff_ffff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AW_MUL,
		ST_AW_ADD,
		ST_MAC,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// operand pair driven into the shared multiplier
	typedef enum logic [2:0] {
		SEL_B0,
		SEL_B1,
		SEL_B2,
		SEL_A1,
		SEL_A2,
		SEL_AW
	} mul_sel_t;

	typedef struct packed {
		logic signed [WordW-1:0] b0;
		logic signed [WordW-1:0] b1;
		logic signed [WordW-1:0] b2;
		logic signed [WordW-1:0] a1;
		logic signed [WordW-1:0] a2;
		logic [GainW-1:0]        inv_gain;
		logic [GainW-1:0]        limit;
	} cfg_t;

	typedef struct packed {
		logic     capture;   // take the input beat, form the plain error
		logic     mul_go;    // load the product register
		mul_sel_t mul_sel;
		logic     aw_add;    // rebuild the error from the anti-windup product
		logic     acc_add;   // fold the registered product into the sum
		logic     finish;    // saturate, clamp, update history, load output
	} cmd_t;

	typedef struct packed {
		logic was_clipped;
		logic out_busy;
	} sts_t;

endpackage

[rtl/qpr_ctrl.sv]
// ----------------------------------------------------------------------------
// qpr_ctrl: sequencer
// Steps one item through the error, five multiply-accumulate slots and the
// final clamp, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module qpr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  qpr_pkg::sts_t  sts,
	output qpr_pkg::cmd_t  cmd
);

	qpr_pkg::state_t state_q, state_d;
	logic [2:0]      slot_q, slot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qpr_pkg::ST_IDLE;
			slot_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.mul_sel = qpr_pkg::SEL_B0;
		unique case (state_q)
			qpr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					slot_d      = 3'd0;
					state_d     = sts.was_clipped ? qpr_pkg::ST_AW_MUL : qpr_pkg::ST_MAC;
				end
			end
			qpr_pkg::ST_AW_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = qpr_pkg::SEL_AW;
				state_d     = qpr_pkg::ST_AW_ADD;
			end
			qpr_pkg::ST_AW_ADD: begin
				cmd.aw_add = 1'b1;
				state_d    = qpr_pkg::ST_MAC;
			end
			qpr_pkg::ST_MAC: begin
				cmd.mul_go  = 1'b1;
				cmd.acc_add = (slot_q != 3'd0);
				unique case (slot_q)
					3'd0:    cmd.mul_sel = qpr_pkg::SEL_B0;
					3'd1:    cmd.mul_sel = qpr_pkg::SEL_B1;
					3'd2:    cmd.mul_sel = qpr_pkg::SEL_B2;
					3'd3:    cmd.mul_sel = qpr_pkg::SEL_A1;
					default: cmd.mul_sel = qpr_pkg::SEL_A2;
				endcase
				slot_d = slot_q + 3'd1;
				if (slot_q == 3'd4) begin
					state_d = qpr_pkg::ST_FLUSH;
				end
			end
			qpr_pkg::ST_FLUSH: begin
				cmd.acc_add = 1'b1;
				state_d     = qpr_pkg::ST_DONE;
			end
			qpr_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = qpr_pkg::ST_IDLE;
				end
			end
			default: state_d = qpr_pkg::ST_IDLE;
		endcase
	end

endmodule

[rtl/qpr_dp.sv]
// ----------------------------------------------------------------------------
// qpr_dp: arithmetic datapath
// Shared 33x33 multiplier, exact accumulator, saturation, clamp, history
// and the output register.
// ----------------------------------------------------------------------------
module qpr_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qpr_pkg::cfg_t                          cfg,
	input  qpr_pkg::cmd_t                          cmd,
	output qpr_pkg::sts_t                          sts,
	input  logic signed [qpr_pkg::WordW-1:0]       setpoint,
	input  logic signed [qpr_pkg::WordW-1:0]       feedback,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [qpr_pkg::WordW-1:0]       drive,
	output logic                                   clipped
);

	localparam int unsigned W = qpr_pkg::WordW;

	function automatic logic signed [W-1:0] sat_word(input logic signed [48:0] v);
		if (v > 49'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -49'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[W-1:0];
	endfunction

	// history
	logic signed [W-1:0] err_q, err_hist1_q, err_hist2_q;
	logic signed [W-1:0] raw_hist1_q, raw_hist2_q, last_drive_q;
	logic                was_clipped_q;

	logic signed [qpr_pkg::ProdW-1:0] prod_s1;
	logic                             neg_s1;
	logic signed [qpr_pkg::AccW-1:0]  acc_q;

	// operand select
	logic signed [W:0]       op_a, op_b;
	logic                    op_neg;
	logic signed [2*W+1:0]   mul_full;

	always_comb begin
		op_neg = 1'b0;
		unique case (cmd.mul_sel)
			qpr_pkg::SEL_B0: begin
				op_a = {cfg.b0[W-1], cfg.b0};
				op_b = {err_q[W-1], err_q};
			end
			qpr_pkg::SEL_B1: begin
				op_a = {cfg.b1[W-1], cfg.b1};
				op_b = {err_hist1_q[W-1], err_hist1_q};
			end
			qpr_pkg::SEL_B2: begin
				op_a = {cfg.b2[W-1], cfg.b2};
				op_b = {err_hist2_q[W-1], err_hist2_q};
			end
			qpr_pkg::SEL_A1: begin
				op_a   = {cfg.a1[W-1], cfg.a1};
				op_b   = {raw_hist1_q[W-1], raw_hist1_q};
				op_neg = 1'b1;
			end
			qpr_pkg::SEL_A2: begin
				op_a   = {cfg.a2[W-1], cfg.a2};
				op_b   = {raw_hist2_q[W-1], raw_hist2_q};
				op_neg = 1'b1;
			end
			qpr_pkg::SEL_AW: begin
				op_a = {last_drive_q[W-1], last_drive_q} - {raw_hist1_q[W-1], raw_hist1_q};
				op_b = {2'b00, cfg.inv_gain};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_full = op_a * op_b;

	// plain error
	logic signed [W:0] diff;
	assign diff = {setpoint[W-1], setpoint} - {feedback[W-1], feedback};

	// anti-windup error: floor(prod >> 16) + err_hist1
	logic signed [47:0] aw_shift;
	logic signed [48:0] aw_sum;
	assign aw_shift = prod_s1[qpr_pkg::ProdW-1:qpr_pkg::AwSh];
	assign aw_sum   = {aw_shift[47], aw_shift} + {{17{err_hist1_q[W-1]}}, err_hist1_q};

	// filter output
	logic signed [qpr_pkg::AccW-1:0]  addend;
	logic signed [38:0]               acc_shift;
	logic signed [W-1:0]              raw, lim_pos, drive_d;
	logic                             clip_d;

	assign addend    = {{3{prod_s1[qpr_pkg::ProdW-1]}}, prod_s1};
	assign acc_shift = acc_q[qpr_pkg::AccW-1:qpr_pkg::FracSh];
	assign raw       = sat_word({{10{acc_shift[38]}}, acc_shift});
	assign lim_pos   = {1'b0, cfg.limit};

	always_comb begin
		if (raw > lim_pos) begin
			drive_d = lim_pos;
		end else if (raw < -lim_pos) begin
			drive_d = -lim_pos;
		end else begin
			drive_d = raw;
		end
		clip_d = (drive_d != raw);
	end

	// product register and accumulator
	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= mul_full[qpr_pkg::ProdW-1:0];
			neg_s1  <= op_neg;
		end
		if (cmd.capture) begin
			acc_q <= '0;
			err_q <= sat_word({{16{diff[W]}}, diff});
		end else begin
			if (cmd.aw_add) begin
				err_q <= sat_word(aw_sum);
			end
			if (cmd.acc_add) begin
				acc_q <= neg_s1 ? acc_q - addend : acc_q + addend;
			end
		end
	end

	// history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_hist1_q   <= '0;
			err_hist2_q   <= '0;
			raw_hist1_q   <= '0;
			raw_hist2_q   <= '0;
			last_drive_q  <= '0;
			was_clipped_q <= 1'b0;
			out_valid     <= 1'b0;
			drive         <= '0;
			clipped       <= 1'b0;
		end else begin
			if (cmd.finish) begin
				err_hist2_q   <= err_hist1_q;
				err_hist1_q   <= err_q;
				raw_hist2_q   <= raw_hist1_q;
				raw_hist1_q   <= raw;
				last_drive_q  <= drive_d;
				was_clipped_q <= clip_d;
				out_valid     <= 1'b1;
				drive         <= drive_d;
				clipped       <= clip_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign sts.was_clipped = was_clipped_q;
	assign sts.out_busy    = out_valid && !out_ready;

endmodule

[rtl/quasi_pr_controller_antiwindup.sv]
// ----------------------------------------------------------------------------
// quasi_pr_controller_antiwindup: quasi-PR controller with anti-windup
// Second-order difference equation on the control error, output clamp and
// error rebuild after a clipped step.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat carries setpoint (low word) and feedback (high
//   word), both signed Q16.16. Master stream: one beat carries the clamped
//   drive in tdata and the clip flag in tuser, one result per input beat.
//   Configuration: write register index and data on the cfg channel while
//   no item is in flight; cfg_ready is always high.
//   When the previous step was clipped, the AW_MUL and AW_ADD states first
//   rebuild the error through the multiplier. The single shared
//   multiplier serves five products one per cycle, and a new item is taken
//   only once the sequencer has finished the last one.
//   The output register lets the next item be accepted while a result waits;
//   a stalled receiver holds the sequencer only at its last step.
//   Reset clears the filter history, loads the coefficients with zero, the
//   inverse gain with 1.0 and the limit with its maximum.
// ----------------------------------------------------------------------------
module quasi_pr_controller_antiwindup (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [63:0]                       s_axis_tdata,   // setpoint[31:0], feedback[63:32]
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,   // drive[31:0]
	output logic                              m_axis_tuser,   // clipped[0]
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qpr_pkg::IndexW-1:0]        cfg_index,
	input  logic [31:0]                       cfg_data
);

	qpr_pkg::cfg_t cfg_q;
	qpr_pkg::cmd_t cmd;
	qpr_pkg::sts_t sts;

	logic signed [31:0] drive;

	// configuration registers; writes to unused indexes drop
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0       <= '0;
			cfg_q.b1       <= '0;
			cfg_q.b2       <= '0;
			cfg_q.a1       <= '0;
			cfg_q.a2       <= '0;
			cfg_q.inv_gain <= qpr_pkg::InvGainReset;
			cfg_q.limit    <= qpr_pkg::LimitReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qpr_pkg::REG_B0:    cfg_q.b0       <= cfg_data;
				qpr_pkg::REG_B1:    cfg_q.b1       <= cfg_data;
				qpr_pkg::REG_B2:    cfg_q.b2       <= cfg_data;
				qpr_pkg::REG_A1:    cfg_q.a1       <= cfg_data;
				qpr_pkg::REG_A2:    cfg_q.a2       <= cfg_data;
				qpr_pkg::REG_INVG:  cfg_q.inv_gain <= cfg_data[qpr_pkg::GainW-1:0];
				qpr_pkg::REG_LIMIT: cfg_q.limit    <= cfg_data[qpr_pkg::GainW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer: accept, error, five products, clamp
	qpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, history and result register
	qpr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.setpoint  (s_axis_tdata[31:0]),
		.feedback  (s_axis_tdata[63:32]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.drive     (drive),
		.clipped   (m_axis_tuser)
	);

	assign m_axis_tdata = drive;

	// one item in flight: no second beat right after an accepted one
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is in flight");

	// a clipped result sits exactly on one of the limits
	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
		(drive == $signed({1'b0, cfg_q.limit}) || drive == -$signed({1'b0, cfg_q.limit})))
		else $error("clipped result off the limit");

	// a result appears only after the sequencer finishes an item
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.finish))
		else $error("result valid without a finished item");

	// never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten while stalled");

endmodule

[tb/tb_quasi_pr_controller_antiwindup.sv]
// ----------------------------------------------------------------------------
// tb_quasi_pr_controller_antiwindup: self-checking bench for the quasi-PR block
// Drives setpoint/feedback beats, writes the coefficient, gain and limit
// registers between batches, and compares every drive/clip beat to a
// hand-typed value or a bit-exact predictor of the filter, clamp and anti-windup rebuild.
// ----------------------------------------------------------------------------
module tb_quasi_pr_controller_antiwindup;

	// wide signed bounds used to saturate exact sums to one word
	localparam logic signed [71:0] WideMax = 72'sh7fff_ffff;
	localparam logic signed [71:0] WideMin = -72'sh8000_0000;
	// index past the last register: the write must leave everything alone
	localparam logic [qpr_pkg::IndexW-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [31:0] drive;
		logic        clipped;
	} result_beat_t;

	typedef enum logic {
		ROW_CFG,
		ROW_ITEM
	} row_kind_t;

	// one directed step: a register write, or an item with an optional
	// hand-typed expectation
	typedef struct {
		row_kind_t                  kind;
		logic [qpr_pkg::IndexW-1:0] idx;
		logic [31:0]                a;      // register data, or setpoint
		logic [31:0]                b;      // feedback
		bit                         typed;
		logic [31:0]                want_drive;
		logic                       want_clip;
	} plan_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [63:0]                s_axis_tdata;   // setpoint[31:0], feedback[63:32]
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [31:0]                m_axis_tdata;   // drive[31:0]
	logic                       m_axis_tuser;   // clipped[0]
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [qpr_pkg::IndexW-1:0] cfg_index;
	logic [31:0]                cfg_data;

	quasi_pr_controller_antiwindup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// register copies held by the predictor
	logic signed [31:0]        k_b0, k_b1, k_b2, k_a1, k_a2;
	logic [qpr_pkg::GainW-1:0] k_inv_gain, k_limit;
	// filter history held by the predictor
	logic signed [31:0] hist_err1, hist_err2, hist_raw1, hist_raw2, hist_drive;
	logic               hist_clip;

	result_beat_t drive_due[$];   // expected result beats, oldest first
	int           mismatch_count;
	int           src_idle_pct;   // chance per cycle that the sender holds off
	int           snk_stall_pct;  // chance per cycle that the receiver stalls
	plan_row_t    plan[$];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic signed [31:0] sat_word(input logic signed [71:0] v);
		if (v > WideMax)
			return 32'sh7fff_ffff;
		if (v < WideMin)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// mirror a register write into the predictor's copy
	function automatic void latch_reg(input logic [qpr_pkg::IndexW-1:0] idx,
			input logic [31:0] val);
		case (idx)
			qpr_pkg::REG_B0:    k_b0 = val;
			qpr_pkg::REG_B1:    k_b1 = val;
			qpr_pkg::REG_B2:    k_b2 = val;
			qpr_pkg::REG_A1:    k_a1 = val;
			qpr_pkg::REG_A2:    k_a2 = val;
			qpr_pkg::REG_INVG:  k_inv_gain = val[qpr_pkg::GainW-1:0];
			qpr_pkg::REG_LIMIT: k_limit = val[qpr_pkg::GainW-1:0];
			default: ;
		endcase
	endfunction

	// advance the filter by one sample and return the drive beat it yields
	function automatic result_beat_t next_drive(input logic signed [31:0] sp,
			input logic signed [31:0] fb);
		logic signed [71:0] wide_err;
		logic signed [71:0] aw_prod;
		logic signed [71:0] acc;
		logic signed [71:0] lim_w;
		logic signed [31:0] err;
		logic signed [31:0] raw;
		logic signed [31:0] drv;
		result_beat_t       res;
		if (hist_clip) begin
			// rebuild the error from the clip amount, ignore the new sample
			aw_prod = (72'(hist_drive) - 72'(hist_raw1)) * $signed({41'b0, k_inv_gain});
			wide_err = (aw_prod >>> qpr_pkg::AwSh) + 72'(hist_err1);
		end else begin
			wide_err = 72'(sp) - 72'(fb);
		end
		err = sat_word(wide_err);
		acc = 72'(k_b0) * 72'(err) + 72'(k_b1) * 72'(hist_err1) + 72'(k_b2) * 72'(hist_err2)
			- 72'(k_a1) * 72'(hist_raw1) - 72'(k_a2) * 72'(hist_raw2);
		raw = sat_word(acc >>> qpr_pkg::FracSh);
		lim_w = $signed({41'b0, k_limit});
		if (72'(raw) > lim_w)
			drv = lim_w[31:0];
		else if (72'(raw) < -lim_w)
			drv = 32'(-lim_w);
		else
			drv = raw;
		hist_err2 = hist_err1;
		hist_err1 = err;
		hist_raw2 = hist_raw1;
		hist_raw1 = raw;
		hist_drive = drv;
		hist_clip = (raw != drv);
		res.drive = drv;
		res.clipped = hist_clip;
		return res;
	endfunction

	// coefficient draw: 0 full range, 1 modest gains, 2 corners
	function automatic logic [31:0] draw_coef(input int style);
		int v;
		case (style)
			0: return $urandom;
			1: begin
				v = int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
				return v;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'h1000_0000;
				endcase
			end
		endcase
	endfunction

	// gain or limit draw; bit 31 may be set and must be ignored by the block
	function automatic logic [31:0] draw_gain(input int style);
		case (style)
			0: return $urandom;
			1: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 32'h0008_0000))};
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'hffff_ffff;
					default: return 32'h0000_0001;
				endcase
			end
		endcase
	endfunction

	// mostly values near the control range, some full-scale noise and corners
	function automatic logic [31:0] draw_sample();
		int roll;
		int v;
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			v = int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			return v;
		end
		if (roll < 90)
			return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	// present one sample beat, with random hold-off, and book its expectation
	task automatic send_item(input logic [31:0] sp, input logic [31:0] fb, input bit typed,
			input logic [31:0] want_drive, input logic want_clip);
		result_beat_t exp_beat;
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {fb, sp};
		do
			@(posedge clk);
		while (!s_axis_tready);
		exp_beat = next_drive(sp, fb);
		if (typed) begin
			exp_beat.drive = want_drive;
			exp_beat.clipped = want_clip;
		end
		drive_due.push_back(exp_beat);
	endtask

	// write one register once every result in flight has come back
	task automatic write_reg(input logic [qpr_pkg::IndexW-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		latch_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver: stall at random per the current phase
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// compare every accepted result beat with the oldest expectation
	always @(posedge clk) begin
		result_beat_t exp_beat;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drive_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: drive=%h clipped=%b",
						m_axis_tdata, m_axis_tuser);
			end else begin
				exp_beat = drive_due.pop_front();
				if (m_axis_tdata !== exp_beat.drive || m_axis_tuser !== exp_beat.clipped) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: drive exp=%h got=%h clipped exp=%b got=%b",
							exp_beat.drive, m_axis_tdata, exp_beat.clipped, m_axis_tuser);
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int style;
		int n;
		int ph;
		int i;
		int r;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		mismatch_count = 0;
		k_b0 = '0;
		k_b1 = '0;
		k_b2 = '0;
		k_a1 = '0;
		k_a2 = '0;
		k_inv_gain = qpr_pkg::InvGainReset;
		k_limit = qpr_pkg::LimitReset;
		hist_err1 = '0;
		hist_err2 = '0;
		hist_raw1 = '0;
		hist_raw2 = '0;
		hist_drive = '0;
		hist_clip = 1'b0;

		// Directed plan. Typed rows follow by hand from the state left by
		// the rows above them; the rest lean on the predictor.
		// zero coefficients out of reset: nothing but zeros, even at full-scale error
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h0000_0000, 0});
		// unity b0: raw follows the error, which saturates at both ends
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B0, 32'h1000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff, 0});
		// most negative raw lands below -limit: clamp to -(2^31-1)
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0001, 1});
		// rebuilt error ignores the sample: one LSB of wind-back
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0000, 1, 32'h8000_0001, 0});
		// limit 1.0, bit 31 of the data must drop
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_LIMIT, 32'h8001_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0002_0000, 32'h0000_0000, 1, 32'h0001_0000, 1});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h1234_5678, 32'h0000_0000, 1, 32'h0001_0000, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'hfffe_0000, 32'h0000_0000, 1, 32'hffff_0000, 1});
		// largest inverse gain, bit 31 of the data must drop
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_INVG, 32'hffff_ffff, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0000, 1, 32'h0001_0000, 1});
		// huge negative wind-back saturates the rebuilt error
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0000, 1, 32'hffff_0000, 1});
		// zero inverse gain: the rebuilt error is just the previous one
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_INVG, 32'h0000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0000, 1, 32'hffff_0000, 1});
		// zero limit clamps everything to zero
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_LIMIT, 32'h0000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h7fff_ffff, 32'h0000_0000, 1, 32'h0000_0000, 1});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_LIMIT, 32'h7fff_ffff, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_INVG, 32'h0001_0000, 32'h0, 0, 32'h0, 0});
		// wind-back of exactly 2^31 cancels the previous error
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 0});
		// out-of-range index must not land anywhere
		plan.push_back('{ROW_CFG,  REG_NONE, 32'hffff_ffff, 32'h0, 0, 32'h0, 0});
		// corner coefficients on every tap
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B0, 32'hffff_ffff, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B1, 32'h8000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B2, 32'h7fff_ffff, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_A1, 32'h8000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_A2, 32'h7fff_ffff, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0000_0000, 32'h0000_0001, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'hffff_ffff, 32'h0000_0000, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B0, 32'h1000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B1, 32'h1000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_B2, 32'h0000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_A1, 32'h7fff_ffff, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_CFG,  qpr_pkg::REG_A2, 32'h8000_0000, 32'h0, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h0001_8000, 32'hffff_4000, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h8000_0001, 32'h0000_0002, 0, 32'h0, 0});
		plan.push_back('{ROW_ITEM, REG_NONE, 32'h5555_5555, 32'haaaa_aaaa, 0, 32'h0, 0});

		// hold reset, then release it away from the rising edge
		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG)
				write_reg(plan[i].idx, plan[i].a);
			else
				send_item(plan[i].a, plan[i].b, plan[i].typed,
					plan[i].want_drive, plan[i].want_clip);
		end

		// Random part: four pacing phases, each running through every
		// register style with fresh settings.
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 49;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 49;
				end
				default: begin
					src_idle_pct = 20;
					snk_stall_pct = 20;
				end
			endcase
			for (style = 0; style < 3; style++) begin
				for (r = 0; r < 5; r++)
					write_reg(qpr_pkg::IndexW'(r), draw_coef(style));
				write_reg(qpr_pkg::REG_INVG, draw_gain(style));
				write_reg(qpr_pkg::REG_LIMIT, draw_gain(style));
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_NONE, $urandom);
				n = 100;
				for (i = 0; i < n; i++)
					send_item(draw_sample(), draw_sample(), 0, 32'h0, 1'b0);
			end
		end

		// drop the input, drain, then give the pipe time for strays
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (drive_due.size() != 0)
			@(posedge clk);
		repeat (24)
			@(posedge clk);

		if (mismatch_count == 0 && drive_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
